FILE: sv/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, token codes and the operator precedence table of the
// infix-to-postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// token kinds
	localparam logic [2:0] FUNC_NUM = 3'd0;
	localparam logic [2:0] FUNC_OP  = 3'd1;
	localparam logic [2:0] FUNC_LP  = 3'd2;
	localparam logic [2:0] FUNC_RP  = 3'd3;
	localparam logic [2:0] FUNC_END = 3'd4;

	// operator codes, plus the stack marker for a left paren
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_SUB    = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_DIV    = 3'd3;
	localparam logic [2:0] OP_POW    = 3'd4;
	localparam logic [2:0] OP_MOD    = 3'd5;
	localparam logic [2:0] OP_LPAREN = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_NUM = 2'd0;
	localparam logic [1:0] KIND_OP  = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_WORK
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctl_cmd_t;

	typedef struct packed {
		logic step_emit;
		logic step_done;
		logic out_free;
	} dp_sts_t;

	function automatic logic [1:0] prec_of(logic [2:0] code);
		logic [1:0] p;
		unique case (code)
			OP_ADD, OP_SUB:         p = 2'd1;
			OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
			OP_POW:                 p = 2'd3;
			default:                p = 2'd0;
		endcase
		return p;
	endfunction

	// stacked operator leaves before the incoming one is pushed
	function automatic logic pops_first(logic [2:0] stacked, logic [2:0] incoming);
		logic r;
		if (incoming == OP_POW) begin
			r = prec_of(stacked) > prec_of(incoming);
		end else begin
			r = prec_of(stacked) >= prec_of(incoming);
		end
		return r;
	endfunction

endpackage

FILE: sv/i2p_if.sv
// ----------------------------------------------------------------------------
// i2p channel interfaces
// Valid/ready channels for infix tokens in and postfix items out.
// ----------------------------------------------------------------------------
interface i2p_tok_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic [2:0]         op_code;
	logic signed [63:0] number_value;

	modport source (output valid, output func, output op_code, output number_value,
		input ready);
	modport sink (input valid, input func, input op_code, input number_value,
		output ready);
endinterface

interface i2p_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         out_kind;
	logic [2:0]         out_op;
	logic signed [63:0] out_value;
	logic [1:0]         status;
	logic               last;

	modport source (output valid, output out_kind, output out_op, output out_value,
		output status, output last, input ready);
	modport sink (input valid, input out_kind, input out_op, input out_value,
		input status, input last, output ready);
endinterface

FILE: sv/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: takes one token, then steps the datapath until the token is done.
// ----------------------------------------------------------------------------
module i2p_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_ready,
	input  i2p_pkg::dp_sts_t    sts,
	output i2p_pkg::ctl_cmd_t   cmd
);

	i2p_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2p_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2p_pkg::S_IDLE: begin
				if (tok_valid) begin
					state_d = i2p_pkg::S_WORK;
				end
			end
			i2p_pkg::S_WORK: begin
				if ((sts.out_free || !sts.step_emit) && sts.step_done) begin
					state_d = i2p_pkg::S_IDLE;
				end
			end
			default: state_d = i2p_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		tok_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			i2p_pkg::S_IDLE: begin
				tok_ready = 1'b1;
				cmd.load  = tok_valid;
			end
			i2p_pkg::S_WORK: begin
				// a step that emits waits for room in the result register
				cmd.step = sts.out_free || !sts.step_emit;
			end
			default: begin
				tok_ready = 1'b0;
			end
		endcase
	end

	a_load_goes_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == i2p_pkg::S_WORK)
		else $error("token load did not start work");

	a_no_emit_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.step_emit) |-> sts.out_free)
		else $error("emit step issued while result register busy");

endmodule

FILE: sv/i2p_datapath.sv
// ----------------------------------------------------------------------------
// i2p_datapath
// Token register, operator stack with a cached top, and the result register.
// ----------------------------------------------------------------------------
module i2p_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  i2p_pkg::ctl_cmd_t   cmd,
	output i2p_pkg::dp_sts_t    sts,
	input  logic [2:0]          func,
	input  logic [2:0]          op_code,
	input  logic signed [63:0]  number_value,
	i2p_res_if.source           result
);

	typedef enum logic [2:0] {
		A_NONE,
		A_NUM,
		A_POP,
		A_DROP,
		A_PUSH,
		A_FAIL,
		A_END,
		A_DISC_END
	} step_act_t;

	logic [2:0]                 func_q;
	logic [2:0]                 code_q;
	logic signed [63:0]         value_q;
	logic [2:0]                 top_q;
	logic [2:0]                 stack_q [i2p_pkg::STACK_DEPTH];
	logic [i2p_pkg::CNT_W-1:0]  stack_count_q;
	logic                       discarding_q;
	logic [1:0]                 held_error_q;

	logic                       out_valid_q;
	logic [1:0]                 out_kind_q;
	logic [2:0]                 out_op_q;
	logic signed [63:0]         out_value_q;
	logic [1:0]                 status_q;
	logic                       last_q;

	logic [i2p_pkg::PTR_W-1:0]  below_idx;
	logic [i2p_pkg::PTR_W-1:0]  wr_idx;
	logic [2:0]                 below;
	logic                       has_top;
	logic                       has_below;
	logic                       top_lp;
	logic                       below_lp;
	logic                       full;

	step_act_t                  act;
	logic                       step_last;
	logic [1:0]                 step_status;
	logic [2:0]                 push_code;
	logic                       step_emit;
	logic                       emit_now;

	// entries below the cached top live in the array
	assign below_idx = i2p_pkg::PTR_W'(stack_count_q - i2p_pkg::CNT_W'(2));
	assign wr_idx    = i2p_pkg::PTR_W'(stack_count_q - i2p_pkg::CNT_W'(1));
	assign below     = stack_q[below_idx];
	assign has_top   = stack_count_q != '0;
	assign has_below = stack_count_q > i2p_pkg::CNT_W'(1);
	assign top_lp    = top_q == i2p_pkg::OP_LPAREN;
	assign below_lp  = below == i2p_pkg::OP_LPAREN;
	assign full      = stack_count_q == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH);

	always_comb begin
		act         = A_NONE;
		step_last   = 1'b1;
		step_status = i2p_pkg::ST_OK;
		push_code   = code_q;
		if (discarding_q) begin
			if (func_q == i2p_pkg::FUNC_END) begin
				act         = A_DISC_END;
				step_status = held_error_q;
			end
		end else begin
			unique case (func_q)
				i2p_pkg::FUNC_NUM: act = A_NUM;
				i2p_pkg::FUNC_OP: begin
					if (code_q <= i2p_pkg::OP_MOD) begin
						if (has_top && !top_lp && i2p_pkg::pops_first(top_q, code_q)) begin
							act       = A_POP;
							// last pop unless the next one pops too
							step_last = !(has_below && !below_lp &&
								i2p_pkg::pops_first(below, code_q));
						end else if (full) begin
							act         = A_FAIL;
							step_status = i2p_pkg::ST_OVERFLOW;
						end else begin
							act = A_PUSH;
						end
					end
				end
				i2p_pkg::FUNC_LP: begin
					push_code = i2p_pkg::OP_LPAREN;
					if (full) begin
						act         = A_FAIL;
						step_status = i2p_pkg::ST_OVERFLOW;
					end else begin
						act = A_PUSH;
					end
				end
				i2p_pkg::FUNC_RP: begin
					if (has_top && !top_lp) begin
						act       = A_POP;
						// matching paren next is dropped silently
						step_last = has_below && below_lp;
					end else if (has_top) begin
						act = A_DROP;
					end else begin
						act         = A_FAIL;
						step_status = i2p_pkg::ST_MISMATCH;
					end
				end
				i2p_pkg::FUNC_END: begin
					if (has_top && !top_lp) begin
						act       = A_POP;
						step_last = 1'b0;
					end else if (has_top) begin
						act         = A_END;
						step_status = i2p_pkg::ST_MISMATCH;
					end else begin
						act = A_END;
					end
				end
				default: act = A_NONE;
			endcase
		end
	end

	assign step_emit = (act == A_NUM) || (act == A_POP) || (act == A_FAIL) ||
		(act == A_END) || (act == A_DISC_END);
	assign emit_now  = cmd.step && step_emit;

	assign sts.step_emit = step_emit;
	assign sts.step_done = act != A_POP;
	assign sts.out_free  = !out_valid_q || result.ready;

	// token and stack payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			code_q  <= op_code;
			value_q <= number_value;
		end
		if (cmd.step) begin
			unique case (act)
				A_POP, A_DROP: top_q <= below;
				A_PUSH: begin
					if (has_top) begin
						stack_q[wr_idx] <= top_q;
					end
					top_q <= push_code;
				end
				default: top_q <= top_q;
			endcase
		end
	end

	// stack control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q <= '0;
			discarding_q  <= 1'b0;
			held_error_q  <= i2p_pkg::ST_OK;
		end else if (cmd.step) begin
			unique case (act)
				A_POP, A_DROP: stack_count_q <= stack_count_q - i2p_pkg::CNT_W'(1);
				A_PUSH:        stack_count_q <= stack_count_q + i2p_pkg::CNT_W'(1);
				A_FAIL: begin
					stack_count_q <= '0;
					discarding_q  <= 1'b1;
					held_error_q  <= step_status;
				end
				A_END:         stack_count_q <= '0;
				A_DISC_END: begin
					discarding_q <= 1'b0;
					held_error_q <= i2p_pkg::ST_OK;
				end
				default:       stack_count_q <= stack_count_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_kind_q  <= i2p_pkg::KIND_NUM;
			out_op_q    <= '0;
			out_value_q <= '0;
			status_q    <= step_status;
			last_q      <= step_last;
			unique case (act)
				A_NUM:             out_value_q <= value_q;
				A_POP: begin
					out_kind_q <= i2p_pkg::KIND_OP;
					out_op_q   <= top_q;
				end
				A_END, A_DISC_END: out_kind_q <= i2p_pkg::KIND_END;
				default:           out_kind_q <= i2p_pkg::KIND_NUM;
			endcase
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_kind  = out_kind_q;
	assign result.out_op    = out_op_q;
	assign result.out_value = out_value_q;
	assign result.status    = status_q;
	assign result.last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_count_q <= i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		discarding_q |-> stack_count_q == '0)
		else $error("stack not empty while discarding");

	a_held_error: assert property (@(posedge clk) disable iff (!arst_n)
		discarding_q == (held_error_q != i2p_pkg::ST_OK))
		else $error("held error out of step with discard flag");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && (act == A_POP || act == A_DROP)) |-> has_top)
		else $error("pop from empty stack");

endmodule

FILE: sv/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard reorder of infix tokens into postfix items on an operator
// stack, with error reporting and discard until the end token.
// ----------------------------------------------------------------------------
//  channel  modport          moves                               per item
//  token    i2p_tok_if.sink  func, op_code, number_value         one token
//  result   i2p_res_if.source out_kind, out_op, out_value,       zero to 33
//                            status, last                        per token
//
// a token is taken in the idle state, then stepped one step a cycle unless
// result stalls: a step per operator popped off the stack, then a final step
// the stack pops one entry per step, which sets the step count for ) and end
// a stall on result holds a step that emits; the token side waits meanwhile
// reset empties the stack and clears the discard state, no sweep needed
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
	input  logic        clk,
	input  logic        arst_n,
	i2p_tok_if.sink     token,
	i2p_res_if.source   result
);

	i2p_pkg::ctl_cmd_t cmd;
	i2p_pkg::dp_sts_t  sts;

	i2p_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (token.valid),
		.tok_ready (token.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	i2p_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (token.func),
		.op_code      (token.op_code),
		.number_value (token.number_value),
		.result       (result)
	);

endmodule
